>>> src/ddrw_pkg.sv
// Package with the shared types and constants of the disk drive read/write logic.
package ddrw_pkg;

    // Number of consecutive ones that pull the sync line low.
    localparam int unsigned SyncOnes = 10;
    // Read shift register width; SyncOnes is never below eight.
    localparam int unsigned ReadShiftW = SyncOnes;

    // Item codes.
    localparam logic CmdCarry = 1'b0;
    localparam logic CmdCpu   = 1'b1;

    // Clock counter phases in the low two bits.
    localparam logic [1:0] PhaseIdle0 = 2'd0;
    localparam logic [1:0] PhaseIdle1 = 2'd1;
    localparam logic [1:0] PhaseShift = 2'd2;
    localparam logic [1:0] PhaseLoad  = 2'd3;

    // Bit count value of the last bit in a byte.
    localparam logic [2:0] LastBit = 3'd7;

    typedef struct packed {
        logic       cmd;
        logic       motor_on;
        logic       head_bit;
        logic       write_mode;
        logic       light_barrier;
        logic [7:0] port_a_byte;
        logic       byte_ready_enable;
    } item_t;

    typedef struct packed {
        logic       byte_ready;
        logic       byte_ready_event;
        logic       sync_line;
        logic       advance_head;
        logic       write_strobe;
        logic       write_bit;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic [3:0]            clock_counter;
        logic [1:0]            carry_divider;
        logic [ReadShiftW-1:0] read_shift;
        logic [7:0]            write_shift;
        logic [2:0]            bit_count;
        logic                  ready_level;
        logic                  sync_state;
    } state_t;

endpackage

>>> src/ddrw_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ddrw_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       motor_on;
    logic       head_bit;
    logic       write_mode;
    logic       light_barrier;
    logic [7:0] port_a_byte;
    logic       byte_ready_enable;

    modport source (output valid, output cmd, output motor_on, output head_bit,
                    output write_mode, output light_barrier, output port_a_byte,
                    output byte_ready_enable, input ready);
    modport sink (input valid, input cmd, input motor_on, input head_bit,
                  input write_mode, input light_barrier, input port_a_byte,
                  input byte_ready_enable, output ready);
endinterface

interface ddrw_result_if;
    logic       valid;
    logic       ready;
    logic       byte_ready;
    logic       byte_ready_event;
    logic       sync_line;
    logic       advance_head;
    logic       write_strobe;
    logic       write_bit;
    logic [7:0] read_data;

    modport source (output valid, output byte_ready, output byte_ready_event,
                    output sync_line, output advance_head, output write_strobe,
                    output write_bit, output read_data, input ready);
    modport sink (input valid, input byte_ready, input byte_ready_event,
                  input sync_line, input advance_head, input write_strobe,
                  input write_bit, input read_data, output ready);
endinterface

>>> src/disk_drive_read_write_logic_unit.sv
// Top level of the floppy drive bit-level read/write logic.
// Usage:
//   cmd_chan carries one item per transaction: a zone clock carry pulse
//   (cmd 0) or a processor cycle (cmd 1) with the drive line levels.
//   res_chan returns exactly one result transaction per input transaction,
//   in order: byte ready level and change, sync, head advance, write strobe
//   and bit, and the low read shift byte.
// Latency: the result is valid in the cycle after the input transaction.
// Throughput: one item per cycle while res_chan takes each result; the whole update is a single pass of
//   logic from the state registers into the state and result registers.
// Stall: cmd_chan.ready stays high while the result register is empty or
//   is being taken in the same cycle; a stalled result holds and blocks
//   further input until it is taken.
// Reset: rst_n clears all drive state (counters, shift registers, byte
//   ready and sync levels) to zero and empties the result register.
module disk_drive_read_write_logic_unit (
    input  logic           clk,
    input  logic           rst_n,
    ddrw_item_if.sink      cmd_chan,
    ddrw_result_if.source  res_chan
);

    ddrw_pkg::state_t  state_reg;
    ddrw_pkg::state_t  state_next;
    ddrw_pkg::item_t   item;
    ddrw_pkg::result_t result_next;
    ddrw_pkg::result_t result_reg;
    logic              valid_reg;
    logic              accept;

    // Gather the input payload
    assign item.cmd               = cmd_chan.cmd;
    assign item.motor_on          = cmd_chan.motor_on;
    assign item.head_bit          = cmd_chan.head_bit;
    assign item.write_mode        = cmd_chan.write_mode;
    assign item.light_barrier     = cmd_chan.light_barrier;
    assign item.port_a_byte       = cmd_chan.port_a_byte;
    assign item.byte_ready_enable = cmd_chan.byte_ready_enable;

    // Accept while the result slot is free or draining
    assign cmd_chan.ready = !valid_reg || res_chan.ready;
    assign accept         = cmd_chan.valid && cmd_chan.ready;

    ddrw_step u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    // Advance drive state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Track the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_chan.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign res_chan.valid            = valid_reg;
    assign res_chan.byte_ready       = result_reg.byte_ready;
    assign res_chan.byte_ready_event = result_reg.byte_ready_event;
    assign res_chan.sync_line        = result_reg.sync_line;
    assign res_chan.advance_head     = result_reg.advance_head;
    assign res_chan.write_strobe     = result_reg.write_strobe;
    assign res_chan.write_bit        = result_reg.write_bit;
    assign res_chan.read_data        = result_reg.read_data;

endmodule

>>> src/ddrw_step.sv
// Next-state and result logic for one carry pulse or processor cycle.
module ddrw_step (
    input  ddrw_pkg::state_t  state,
    input  ddrw_pkg::item_t   item,
    output ddrw_pkg::state_t  state_next,
    output ddrw_pkg::result_t result
);

    logic [3:0] cc_inc;
    logic [1:0] cd_inc;
    logic       qb;
    logic       ready_cond;
    logic       level;
    logic       sync_new;
    logic [2:0] bc_base;
    logic       advance;
    logic       strobe;
    logic       wbit;
    logic       event_flag;

    always_comb
    begin
        state_next = state;
        advance    = 1'b0;
        strobe     = 1'b0;
        wbit       = 1'b0;
        event_flag = 1'b0;
        cc_inc     = state.clock_counter + 4'd1;
        cd_inc     = state.carry_divider + 2'd1;
        sync_new   = state.sync_state;
        bc_base    = state.bit_count;
        qb         = 1'b0;
        ready_cond = 1'b0;
        level      = 1'b0;

        if (item.cmd == ddrw_pkg::CmdCpu)
        begin
            // Re-evaluate byte ready from the current counters
            qb         = state.clock_counter[1];
            ready_cond = item.byte_ready_enable && !qb && (state.bit_count == ddrw_pkg::LastBit);
            level      = !ready_cond;
            if (level != state.ready_level)
            begin
                state_next.ready_level = level;
                event_flag             = 1'b1;
            end
        end
        else if (item.motor_on)
        begin
            // Step the clock counter and divider; every fourth pulse moves the disk
            state_next.clock_counter = cc_inc;
            state_next.carry_divider = cd_inc;
            if (cd_inc == 2'd0)
            begin
                if (!item.write_mode && item.head_bit)
                begin
                    state_next.clock_counter = 4'd0;
                end
                advance = 1'b1;
            end

            // Derive sync from a run of ones in the read register; write mode holds sync inactive
            sync_new = (state.read_shift != {ddrw_pkg::ReadShiftW{1'b1}}) || item.write_mode;
            state_next.sync_state = sync_new;
            bc_base = sync_new ? state.bit_count : 3'd0;
            state_next.bit_count = bc_base;

            unique case (state_next.clock_counter[1:0])
                ddrw_pkg::PhaseIdle0,
                ddrw_pkg::PhaseIdle1:
                begin
                    qb         = state_next.clock_counter[1];
                    ready_cond = item.byte_ready_enable && !qb
                                 && (bc_base == ddrw_pkg::LastBit);
                    level      = !ready_cond;
                    if (level != state.ready_level)
                    begin
                        state_next.ready_level = level;
                        event_flag             = 1'b1;
                    end
                end
                ddrw_pkg::PhaseShift:
                begin
                    // Release byte ready, count the bit, shift both registers
                    if (!state.ready_level)
                    begin
                        state_next.ready_level = 1'b1;
                        event_flag             = 1'b1;
                    end
                    state_next.bit_count = sync_new ? (bc_base + 3'd1) : 3'd0;
                    if (item.write_mode && !item.light_barrier)
                    begin
                        strobe = 1'b1;
                        wbit   = state.write_shift[7];
                    end
                    state_next.write_shift = {state.write_shift[6:0], 1'b0};
                    state_next.read_shift  = {state.read_shift[ddrw_pkg::ReadShiftW-2:0],
                                              (state_next.clock_counter[3:2] == 2'b00)};
                end
                ddrw_pkg::PhaseLoad:
                begin
                    // Load the next write byte at the end of a byte
                    if (bc_base == ddrw_pkg::LastBit)
                    begin
                        state_next.write_shift = item.port_a_byte;
                    end
                end
                default:
                begin
                    state_next.write_shift = state.write_shift;
                end
            endcase
        end

        result.byte_ready       = state_next.ready_level;
        result.byte_ready_event = event_flag;
        result.sync_line        = state_next.sync_state;
        result.advance_head     = advance;
        result.write_strobe     = strobe;
        result.write_bit        = wbit;
        result.read_data        = state_next.read_shift[7:0];
    end

endmodule
